>>> sv/xcr_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM checksum receiver package
// Shared types, character codes and event codes of the receiver.
// ----------------------------------------------------------------------------
package xcr_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int INDEX_BITS  = $clog2(BLOCK_BYTES);
  localparam int SIZE_BITS   = 24;
  localparam int TICK_BITS   = 24;

  localparam logic [TICK_BITS-1:0] NAK_INTERVAL_RESET = 24'd2000000;

  // Control characters of the line protocol.
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] INV_OK = 8'hff;

  typedef enum logic [2:0] {
    EV_ACK      = 3'd0,
    EV_NAK      = 3'd1,
    EV_WRITE    = 3'd2,
    EV_FINISH   = 3'd3,
    EV_CANCEL   = 3'd4,
    EV_OVERFLOW = 3'd5
  } event_code_t;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_NUMBER  = 6'b000010,
    PH_INVERSE = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CHECK   = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  // One queued event. The value field carries the write address on a
  // write event and the committed size on a finished event.
  typedef struct packed {
    event_code_t          ev;
    logic [7:0]           data;
    logic [SIZE_BITS-1:0] value;
  } event_t;

endpackage

>>> sv/xcr_front.sv
// ----------------------------------------------------------------------------
// XMODEM receiver front end
// Accepts bytes and ticks, runs the block protocol and emits events.
// ----------------------------------------------------------------------------
module xcr_front #(
  parameter int ADDRESS_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           kind,
  input  logic [7:0]                     rx_byte,
  input  logic                           nak_interval_we,
  input  logic [xcr_pkg::TICK_BITS-1:0]  nak_interval,
  output logic                           push,
  output xcr_pkg::event_t                push_entry
);

  xcr_pkg::phase_t                 phase, phase_next;
  logic                            block_started, block_started_next;
  logic [7:0]                      expected_block, expected_block_next;
  logic [7:0]                      number_byte, number_byte_next;
  logic [xcr_pkg::INDEX_BITS-1:0]  payload_index, payload_index_next;
  logic [7:0]                      running_sum, running_sum_next;
  logic [ADDRESS_BITS:0]           committed_size, committed_size_next;
  logic [xcr_pkg::TICK_BITS-1:0]   idle_ticks, idle_ticks_next;
  logic [xcr_pkg::TICK_BITS-1:0]   interval;

  logic [xcr_pkg::TICK_BITS-1:0]   idle_inc;
  logic [ADDRESS_BITS:0]           addr;
  logic [ADDRESS_BITS+24:0]        addr_ext;
  logic [ADDRESS_BITS+24:0]        size_ext;

  assign idle_inc = idle_ticks + 24'd1;
  assign addr     = committed_size + (ADDRESS_BITS+1)'(payload_index);
  assign addr_ext = (ADDRESS_BITS+25)'(addr);
  assign size_ext = (ADDRESS_BITS+25)'(committed_size);

  always_comb begin
    phase_next          = phase;
    block_started_next  = block_started;
    expected_block_next = expected_block;
    number_byte_next    = number_byte;
    payload_index_next  = payload_index;
    running_sum_next    = running_sum;
    committed_size_next = committed_size;
    idle_ticks_next     = idle_ticks;
    push                = 1'b0;
    push_entry.ev       = xcr_pkg::EV_NAK;
    push_entry.data     = 8'd0;
    push_entry.value    = '0;

    if (accept && phase != xcr_pkg::PH_DONE) begin
      if (kind) begin
        // Ticks only matter while waiting for the very first header.
        if (phase == xcr_pkg::PH_HEADER && !block_started) begin
          if (idle_inc >= interval) begin
            idle_ticks_next = '0;
            push            = 1'b1;
          end else begin
            idle_ticks_next = idle_inc;
          end
        end
      end else begin
        case (phase)
          xcr_pkg::PH_HEADER: begin
            idle_ticks_next = '0;
            if (rx_byte == xcr_pkg::CH_EOT) begin
              phase_next       = xcr_pkg::PH_DONE;
              push             = 1'b1;
              push_entry.ev    = xcr_pkg::EV_FINISH;
              push_entry.value = size_ext[23:0];
            end else if (rx_byte == xcr_pkg::CH_CAN) begin
              phase_next    = xcr_pkg::PH_DONE;
              push          = 1'b1;
              push_entry.ev = xcr_pkg::EV_CANCEL;
            end else if (rx_byte == xcr_pkg::CH_SOH) begin
              block_started_next = 1'b1;
              phase_next         = xcr_pkg::PH_NUMBER;
            end else if (block_started) begin
              phase_next    = xcr_pkg::PH_DONE;
              push          = 1'b1;
              push_entry.ev = xcr_pkg::EV_CANCEL;
            end
          end
          xcr_pkg::PH_NUMBER: begin
            if (rx_byte != expected_block) begin
              phase_next = xcr_pkg::PH_HEADER;
              push       = 1'b1;
            end else begin
              number_byte_next = rx_byte;
              phase_next       = xcr_pkg::PH_INVERSE;
            end
          end
          xcr_pkg::PH_INVERSE: begin
            if ((number_byte ^ rx_byte) != xcr_pkg::INV_OK) begin
              phase_next = xcr_pkg::PH_HEADER;
              push       = 1'b1;
            end else begin
              payload_index_next = '0;
              running_sum_next   = 8'd0;
              phase_next         = xcr_pkg::PH_PAYLOAD;
            end
          end
          xcr_pkg::PH_PAYLOAD: begin
            push = 1'b1;
            if (addr[ADDRESS_BITS]) begin
              phase_next    = xcr_pkg::PH_DONE;
              push_entry.ev = xcr_pkg::EV_OVERFLOW;
            end else begin
              running_sum_next   = running_sum + rx_byte;
              payload_index_next = payload_index + 1'b1;
              if (payload_index == xcr_pkg::INDEX_BITS'(xcr_pkg::BLOCK_BYTES - 1)) begin
                phase_next = xcr_pkg::PH_CHECK;
              end
              push_entry.ev    = xcr_pkg::EV_WRITE;
              push_entry.data  = rx_byte;
              push_entry.value = addr_ext[23:0];
            end
          end
          xcr_pkg::PH_CHECK: begin
            phase_next = xcr_pkg::PH_HEADER;
            push       = 1'b1;
            if (running_sum == rx_byte) begin
              committed_size_next = committed_size
                                    + (ADDRESS_BITS+1)'(xcr_pkg::BLOCK_BYTES);
              expected_block_next = expected_block + 8'd1;
              push_entry.ev       = xcr_pkg::EV_ACK;
            end
          end
          default: begin
            phase_next = xcr_pkg::PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= xcr_pkg::PH_HEADER;
      block_started  <= 1'b0;
      expected_block <= 8'd1;
      number_byte    <= 8'd0;
      payload_index  <= '0;
      running_sum    <= 8'd0;
      committed_size <= '0;
      idle_ticks     <= '0;
      interval       <= xcr_pkg::NAK_INTERVAL_RESET;
    end else begin
      phase          <= phase_next;
      block_started  <= block_started_next;
      expected_block <= expected_block_next;
      number_byte    <= number_byte_next;
      payload_index  <= payload_index_next;
      running_sum    <= running_sum_next;
      committed_size <= committed_size_next;
      idle_ticks     <= idle_ticks_next;
      if (nak_interval_we) begin
        interval <= nak_interval;
      end
    end
  end

endmodule

>>> sv/xcr_queue.sv
// ----------------------------------------------------------------------------
// XMODEM receiver event queue
// Two-entry queue that decouples the protocol front end from the output.
// ----------------------------------------------------------------------------
module xcr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xcr_pkg::event_t push_entry,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output xcr_pkg::event_t pop_entry
);

  xcr_pkg::event_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign do_pop    = pop && pop_valid;
  assign pop_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

>>> sv/xcr_back.sv
// ----------------------------------------------------------------------------
// XMODEM receiver back end
// Takes queued events and presents them in the output register.
// ----------------------------------------------------------------------------
module xcr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  xcr_pkg::event_t                q_entry,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     event_res,
  output logic [7:0]                     data_byte,
  output logic [xcr_pkg::SIZE_BITS-1:0]  write_address,
  output logic [xcr_pkg::SIZE_BITS-1:0]  total_size
);

  logic load;

  assign load  = !out_valid || out_ready;
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
    end
  end

  // The shared value field is routed to the one port that means something
  // for this event; the other port reads zero.
  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      event_res     <= q_entry.ev;
      data_byte     <= q_entry.data;
      write_address <= (q_entry.ev == xcr_pkg::EV_WRITE)  ? q_entry.value : '0;
      total_size    <= (q_entry.ev == xcr_pkg::EV_FINISH) ? q_entry.value : '0;
    end
  end

endmodule

>>> sv/xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// XMODEM checksum receiver
// Receiver side of XMODEM with an 8-bit additive checksum and 128-byte blocks.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): each transaction is either a received
// byte (kind = 0, rx_byte) or an idle tick (kind = 1). Output channel
// (out_valid/out_ready): each transaction is one event: ACK, NAK, a data
// write with data_byte and write_address, finished with total_size,
// cancelled or overflow abort. An input transaction yields at most one event.
// The user writes the NAK start interval through nak_interval_we/nak_interval
// only while the block is idle, a rule the block itself does not enforce.
// One input transaction is taken every cycle while in_ready is high. The front
// end decides an event in the accepting cycle; it enters a two-entry queue at
// that edge and moves into the output register when that register is free.
// When the receiver stalls, the queue fills and in_ready drops once both
// entries are occupied; nothing is lost.
// Reset clears the protocol state, empties the queue and the output register,
// and restores the NAK interval to 2000000 ticks. After finished or an abort,
// input transactions are accepted and ignored until the next reset.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver #(
  parameter int ADDRESS_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [23:0] write_address,
  output logic [23:0] total_size,
  input  logic        nak_interval_we,
  input  logic [23:0] nak_interval
);

  logic            accept;
  logic            push;
  xcr_pkg::event_t push_entry;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  xcr_pkg::event_t q_entry;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  xcr_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .kind            (kind),
    .rx_byte         (rx_byte),
    .nak_interval_we (nak_interval_we),
    .nak_interval    (nak_interval),
    .push            (push),
    .push_entry      (push_entry)
  );

  xcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  xcr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .data_byte     (data_byte),
    .write_address (write_address),
    .total_size    (total_size)
  );

endmodule

>>> sv/xcr_checker.sv
// ----------------------------------------------------------------------------
// XMODEM receiver port checker
// Watches the top-level ports for handshake and event consistency.
// ----------------------------------------------------------------------------
module xcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_res,
  input logic [7:0]  data_byte,
  input logic [23:0] write_address,
  input logic [23:0] total_size
);

  // A stalled event must hold its value until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res)
                                && $stable(write_address))
    else $error("output event changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != xcr_pkg::EV_WRITE |-> write_address == 24'd0
                                                    && data_byte == 8'd0)
    else $error("write fields set on a non-write event");

  a_size_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != xcr_pkg::EV_FINISH |-> total_size == 24'd0)
    else $error("total size set on a non-finish event");

  // Committed sizes are always whole blocks.
  a_size_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == xcr_pkg::EV_FINISH |-> total_size[6:0] == 7'd0)
    else $error("finished size is not a whole number of blocks");

endmodule

bind xmodem_checksum_receiver xcr_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .event_res     (event_res),
  .data_byte     (data_byte),
  .write_address (write_address),
  .total_size    (total_size)
);

>>> tb/xmodem_checksum_receiver_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM checksum receiver checker
// Watches both channels and the interval register port of the receiver. It
// predicts the event, if any, that an input transaction raises, queues it, and
// compares each output transaction field by field against the oldest queued
// event. It reports the failure count and the number of events still due.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  event_res,
  input  logic [7:0]  data_byte,
  input  logic [23:0] write_address,
  input  logic [23:0] total_size,
  input  logic        nak_interval_we,
  input  logic [23:0] nak_interval,
  output int          errors,
  output int          pending,
  output int          events_checked
);

  typedef struct packed {
    xcr_pkg::event_code_t          ev;
    logic [7:0]                    data;
    logic [xcr_pkg::SIZE_BITS-1:0] addr;
    logic [xcr_pkg::SIZE_BITS-1:0] size;
  } rx_event_t;

  rx_event_t events_due[$];

  // Receiver state as the protocol defines it.
  xcr_pkg::phase_t               stage;
  logic                          block_open;
  logic [7:0]                    want_block;
  logic [7:0]                    number_seen;
  logic [7:0]                    byte_idx;
  logic [7:0]                    csum;
  logic [xcr_pkg::SIZE_BITS:0]   committed;
  logic [xcr_pkg::TICK_BITS-1:0] tick_count;
  logic [xcr_pkg::TICK_BITS-1:0] tick_limit;

  task automatic queue_event(input xcr_pkg::event_code_t ev, input logic [7:0] data,
                             input logic [xcr_pkg::SIZE_BITS-1:0] addr,
                             input logic [xcr_pkg::SIZE_BITS-1:0] size);
    rx_event_t e;
    e.ev   = ev;
    e.data = data;
    e.addr = addr;
    e.size = size;
    events_due.push_back(e);
  endtask

  task automatic advance_protocol(input logic is_tick, input logic [7:0] b);
    logic [xcr_pkg::SIZE_BITS:0] addr;
    if (stage == xcr_pkg::PH_DONE) return;
    if (is_tick) begin
      // Ticks only matter while waiting for the very first block.
      if (stage == xcr_pkg::PH_HEADER && !block_open) begin
        tick_count = tick_count + 1'b1;
        if (tick_count >= tick_limit) begin
          tick_count = '0;
          queue_event(xcr_pkg::EV_NAK, '0, '0, '0);
        end
      end
      return;
    end
    case (stage)
      xcr_pkg::PH_HEADER: begin
        tick_count = '0;
        if (b == xcr_pkg::CH_EOT) begin
          stage = xcr_pkg::PH_DONE;
          queue_event(xcr_pkg::EV_FINISH, '0, '0, committed[xcr_pkg::SIZE_BITS-1:0]);
        end else if (b == xcr_pkg::CH_CAN) begin
          stage = xcr_pkg::PH_DONE;
          queue_event(xcr_pkg::EV_CANCEL, '0, '0, '0);
        end else if (b == xcr_pkg::CH_SOH) begin
          block_open = 1'b1;
          stage      = xcr_pkg::PH_NUMBER;
        end else if (block_open) begin
          stage = xcr_pkg::PH_DONE;
          queue_event(xcr_pkg::EV_CANCEL, '0, '0, '0);
        end
      end
      xcr_pkg::PH_NUMBER: begin
        if (b != want_block) begin
          stage = xcr_pkg::PH_HEADER;
          queue_event(xcr_pkg::EV_NAK, '0, '0, '0);
        end else begin
          number_seen = b;
          stage       = xcr_pkg::PH_INVERSE;
        end
      end
      xcr_pkg::PH_INVERSE: begin
        if ((number_seen ^ b) != xcr_pkg::INV_OK) begin
          stage = xcr_pkg::PH_HEADER;
          queue_event(xcr_pkg::EV_NAK, '0, '0, '0);
        end else begin
          byte_idx = '0;
          csum     = '0;
          stage    = xcr_pkg::PH_PAYLOAD;
        end
      end
      xcr_pkg::PH_PAYLOAD: begin
        addr = committed + (xcr_pkg::SIZE_BITS+1)'(byte_idx);
        if (addr[xcr_pkg::SIZE_BITS]) begin
          stage = xcr_pkg::PH_DONE;
          queue_event(xcr_pkg::EV_OVERFLOW, '0, '0, '0);
        end else begin
          csum     = csum + b;
          byte_idx = byte_idx + 1'b1;
          if (byte_idx >= xcr_pkg::BLOCK_BYTES) stage = xcr_pkg::PH_CHECK;
          queue_event(xcr_pkg::EV_WRITE, b, addr[xcr_pkg::SIZE_BITS-1:0], '0);
        end
      end
      xcr_pkg::PH_CHECK: begin
        stage = xcr_pkg::PH_HEADER;
        if (csum != b) begin
          queue_event(xcr_pkg::EV_NAK, '0, '0, '0);
        end else begin
          committed  = committed + (xcr_pkg::SIZE_BITS+1)'(xcr_pkg::BLOCK_BYTES);
          want_block = want_block + 1'b1;
          queue_event(xcr_pkg::EV_ACK, '0, '0, '0);
        end
      end
      default: stage = xcr_pkg::PH_DONE;
    endcase
  endtask

  always @(posedge clk) begin
    rx_event_t got;
    rx_event_t want;
    if (rst) begin
      stage          = xcr_pkg::PH_HEADER;
      block_open     = 1'b0;
      want_block     = 8'd1;
      number_seen    = '0;
      byte_idx       = '0;
      csum           = '0;
      committed      = '0;
      tick_count     = '0;
      tick_limit     = xcr_pkg::NAK_INTERVAL_RESET;
      errors         = 0;
      events_checked = 0;
      events_due.delete();
    end else begin
      if (nak_interval_we) tick_limit = nak_interval;
      // Each event passes the queue and the output register before it shows, so compare first.
      if (out_valid && out_ready) begin
        got.ev   = xcr_pkg::event_code_t'(event_res);
        got.data = data_byte;
        got.addr = write_address;
        got.size = total_size;
        events_checked++;
        if (events_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: event %0d with no transaction pending",
                     $realtime, event_res);
        end else begin
          want = events_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch: expected ev %0d data %02h addr %06h size %06h,",
                        " got ev %0d data %02h addr %06h size %06h"},
                       $realtime, want.ev, want.data, want.addr, want.size,
                       event_res, data_byte, write_address, total_size);
          end
        end
      end
      if (in_valid && in_ready) advance_protocol(kind, rx_byte);
    end
    pending = events_due.size();
  end

endmodule

>>> tb/xmodem_checksum_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM checksum receiver testbench
// Walks the start-request timer through several interval settings, then
// streams good and damaged blocks with random content, idle gaps on both
// channels and one long output stall, and ends the transfer once. A checker
// beside the receiver predicts and compares every event.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_test;

  localparam int ITEMS       = 1350;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_FROM   = 600;
  localparam int CALM_TO     = 900;
  localparam int SETTLE      = 8;
  localparam int LIMIT_NS    = 2000000;

  // Line characters that the receiver treats as ordinary bytes.
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;

  typedef enum logic [1:0] {END_EOT, END_CAN, END_STRAY} wrap_up_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [23:0] write_address;
  logic [23:0] total_size;
  logic        nak_interval_we = 1'b0;
  logic [23:0] nak_interval = 24'h000000;

  int errors;
  int pending;
  int events_checked;
  int stream_items = 0;
  int good_blocks = 0;
  int rejected_blocks = 0;
  string end_name;

  xmodem_checksum_receiver u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_res       (event_res),
    .data_byte       (data_byte),
    .write_address   (write_address),
    .total_size      (total_size),
    .nak_interval_we (nak_interval_we),
    .nak_interval    (nak_interval)
  );

  xmodem_checksum_receiver_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_res       (event_res),
    .data_byte       (data_byte),
    .write_address   (write_address),
    .total_size      (total_size),
    .nak_interval_we (nak_interval_we),
    .nak_interval    (nak_interval),
    .errors          (errors),
    .pending         (pending),
    .events_checked  (events_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("xmodem_checksum_receiver_test NOT OK");
    $finish;
  end

  // Receiver side: random stalls, one quiet stretch, and one long hold-off
  // that fills the receiver's queue while the sender keeps offering.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!hold_done && stream_items >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stream_items >= CALM_FROM && stream_items < CALM_TO) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // Offers one transaction and returns at the edge that accepts it.
  task automatic push(input logic is_tick, input logic [7:0] b, input bit counted);
    if (!(stream_items >= CALM_FROM && stream_items < CALM_TO) && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= is_tick;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    if (counted) stream_items++;
  endtask

  // A line byte, now and then preceded by a tick that the receiver ignores once the first header is in.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < 3) push(1'b1, 8'($urandom_range(255)), 1'b0);
    push(1'b0, b, 1'b1);
  endtask

  // Waits for the receiver to drain, then writes the interval register.
  task automatic set_interval(input logic [23:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
    nak_interval_we <= 1'b1;
    nak_interval    <= value;
    @(posedge clk);
    nak_interval_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] want_num;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] flip;
    int pick;
    int fill;
    wrap_up_t wrap_up;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Start-request timer under the reset interval, zero, the maximum, one
    // and a small value, with stray bytes restarting the tick count.
    repeat (3) push(1'b1, 8'($urandom_range(255)), 1'b1);
    set_interval(24'h000000);
    repeat (3) push(1'b1, 8'($urandom_range(255)), 1'b1);
    set_interval(24'hffffff);
    repeat (3) push(1'b1, 8'($urandom_range(255)), 1'b1);
    set_interval(24'h000001);
    repeat (2) push(1'b1, 8'($urandom_range(255)), 1'b1);
    set_interval(24'($urandom_range(2, 5)));
    push(1'b1, 8'hff, 1'b1);
    push(1'b1, 8'h00, 1'b1);
    push(1'b0, CH_NAK, 1'b1);
    push(1'b1, 8'($urandom_range(255)), 1'b1);
    push(1'b0, 8'hff, 1'b1);
    push(1'b1, 8'($urandom_range(255)), 1'b1);
    push(1'b0, CH_ACK, 1'b1);
    push(1'b0, 8'h00, 1'b1);
    repeat (5) push(1'b1, 8'($urandom_range(255)), 1'b1);

    want_num = 8'd1;
    while (stream_items < ITEMS) begin
      pick = $urandom_range(99);
      flip = 8'($urandom_range(1, 255));
      if (pick < 10) begin
        // Wrong block number; the sender retries with a fresh header.
        send_byte(xcr_pkg::CH_SOH);
        send_byte(want_num ^ flip);
        rejected_blocks++;
      end else if (pick < 20) begin
        send_byte(xcr_pkg::CH_SOH);
        send_byte(want_num);
        b = ~want_num ^ flip;
        send_byte(b);
        rejected_blocks++;
      end else if (pick < 25) begin
        repeat ($urandom_range(1, 4)) push(1'b1, 8'($urandom_range(255)), 1'b0);
      end else begin
        fill = $urandom_range(9);
        sum  = 8'h00;
        send_byte(xcr_pkg::CH_SOH);
        send_byte(want_num);
        send_byte(~want_num);
        for (int i = 0; i < xcr_pkg::BLOCK_BYTES; i++) begin
          if (fill == 0) b = 8'h00;
          else if (fill == 1) b = 8'hff;
          else b = 8'($urandom_range(255));
          sum = sum + b;
          send_byte(b);
        end
        if ($urandom_range(99) < 20) begin
          send_byte(sum ^ flip);
          rejected_blocks++;
        end else begin
          send_byte(sum);
          want_num = want_num + 1'b1;
          good_blocks++;
        end
      end
    end

    // The transfer ends exactly once per reset.
    wrap_up = wrap_up_t'($urandom_range(2));
    case (wrap_up)
      END_EOT: begin
        end_name = "end of transmission";
        send_byte(xcr_pkg::CH_EOT);
      end
      END_CAN: begin
        end_name = "cancel";
        send_byte(xcr_pkg::CH_CAN);
      end
      default: begin
        end_name = "stray byte";
        do b = 8'($urandom_range(255));
        while (b == xcr_pkg::CH_SOH || b == xcr_pkg::CH_EOT || b == xcr_pkg::CH_CAN);
        send_byte(b);
      end
    endcase
    // Everything after the end must be swallowed silently.
    push(1'b0, xcr_pkg::CH_SOH, 1'b0);
    push(1'b1, 8'($urandom_range(255)), 1'b0);
    repeat (4) push(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0);
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d line transactions: %0d good and %0d rejected blocks,",
             stream_items, good_blocks, rejected_blocks);
    $display("%0d events checked; start-request timer run at five interval settings;",
             events_checked);
    $display("transfer closed by %s.", end_name);
    if (errors == 0) begin
      $display("xmodem_checksum_receiver_test OK");
    end else begin
      $display("%0d failures", errors);
      $display("xmodem_checksum_receiver_test NOT OK");
    end
    $finish;
  end

endmodule
